### hdl/rotating_text_slot_display_assert.svh
// Assertion macros used by the rotating text slot display checker.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ROTATING_TEXT_SLOT_DISPLAY_ASSERT_SVH
`define ROTATING_TEXT_SLOT_DISPLAY_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define RTSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rtsd: assertion failed");

// Next-cycle implication, disabled in reset
`define RTSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rtsd: assertion failed");

`endif

### hdl/rtsd_pkg.sv
// Package for the rotating text slot display: sizes, codes, payload types.
// No dependencies; used by the interfaces, the top level and the checker.
`default_nettype none

package rtsd_pkg;

  localparam int MAX_WIDTH   = 32;
  localparam int MAX_SLOTS   = 8;
  localparam int STORE_BYTES = (MAX_WIDTH + 1) * MAX_SLOTS;
  localparam int ADDR_W      = $clog2(STORE_BYTES + 1);

  localparam logic [16:0] ELAPSED_MAX = 17'h1FFFF;
  localparam logic [7:0]  PAD_CHAR    = 8'h20;

  localparam logic [5:0]  SLOT_WIDTH_RST = 6'd16;
  localparam logic [3:0]  SLOT_COUNT_RST = 4'd4;
  localparam logic [15:0] ITEM_DELAY_RST = 16'd1500;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_SELECT = 3'd1,
    CMD_WRITE  = 3'd2,
    CMD_CLEAR  = 3'd3,
    CMD_RENDER = 3'd4
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SLOT_WIDTH = 2'd0,
    CFG_SLOT_COUNT = 2'd1,
    CFG_ITEM_DELAY = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_TERM,
    S_RENDER
  } state_e;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] slot_index;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/rtsd_if.sv
// Handshake interfaces for the rotating text slot display channels.
// Depends on rtsd_pkg for the payload types and configuration sizes.
`default_nettype none

interface rtsd_in_if
  import rtsd_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtsd_out_if
  import rtsd_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rtsd_cfg_if
  import rtsd_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/rotating_text_slot_display.sv
// Rotating text slot display: tick, select, write, clear and render commands in,
// one word is taken per cycle while idle; a write that leaves room adds a terminator write.
// Render: the command is taken, then the clamped slot width in characters at one per
// cycle, unless the output stalls, from the store's single read port; each shows in
// the cycle after its read. Reset: a clearing pass zeroes all 264 store bytes; input
// not ready meanwhile, configuration writes taken throughout. Depends on rtsd_pkg and rtsd_if.
`default_nettype none

module rotating_text_slot_display
  import rtsd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rtsd_cfg_if.sink    cfg_i,
  rtsd_in_if.sink     in_i,
  rtsd_out_if.source  out_o
);

  // Configuration registers
  logic [5:0]  slot_width_q;
  logic [3:0]  slot_count_q;
  logic [15:0] item_delay_q;

  // Control state
  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [ADDR_W-1:0] wp_q, wp_d;
  logic [2:0]        shown_q, shown_d;
  logic [16:0]       elapsed_q, elapsed_d;
  logic [4:0]        rd_idx_q, rd_idx_d;
  logic [ADDR_W-1:0] base_q, base_d;

  // Read pipeline
  logic       rd_valid_q;
  logic       rd_first_q;
  logic       rd_last_q;
  logic       ended_q;
  logic [7:0] rdata_q;

  // Store
  logic [7:0]        mem [STORE_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [5:0]        w_eff;
  logic [3:0]        n_eff;
  logic [5:0]        stride;
  logic [ADDR_W-1:0] store_end;
  logic [ADDR_W-1:0] sel_pos;
  logic [ADDR_W-1:0] base_now;
  logic [ADDR_W-1:0] wp_inc;
  logic [3:0]        shown_inc;
  logic              in_fire;
  logic              issue;
  logic              rd_last;
  logic              ended_now;

  // Clamp configuration to the supported range
  always_comb begin
    if (slot_width_q == 6'd0) begin
      w_eff = 6'd1;
    end else if (slot_width_q > 6'(MAX_WIDTH)) begin
      w_eff = 6'(MAX_WIDTH);
    end else begin
      w_eff = slot_width_q;
    end
    if (slot_count_q == 4'd0) begin
      n_eff = 4'd1;
    end else if (slot_count_q > 4'(MAX_SLOTS)) begin
      n_eff = 4'(MAX_SLOTS);
    end else begin
      n_eff = slot_count_q;
    end
  end

  assign stride    = w_eff + 6'd1;
  assign store_end = ADDR_W'(stride * n_eff);
  assign sel_pos   = ADDR_W'(in_i.data.slot_index[2:0] * stride);
  assign base_now  = ADDR_W'(shown_q * stride);
  assign wp_inc    = wp_q + ADDR_W'(1);
  assign shown_inc = {1'b0, shown_q} + 4'd1;

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign issue       = !rd_valid_q || out_o.ready;
  assign rd_last     = (rd_idx_q == 5'(w_eff - 6'd1));
  assign mem_raddr   = base_q + ADDR_W'(rd_idx_q);

  // Configuration port: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_width_q <= SLOT_WIDTH_RST;
      slot_count_q <= SLOT_COUNT_RST;
      item_delay_q <= ITEM_DELAY_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_SLOT_WIDTH: slot_width_q <= cfg_i.data[5:0];
        CFG_SLOT_COUNT: slot_count_q <= cfg_i.data[3:0];
        CFG_ITEM_DELAY: item_delay_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Next state, store accesses and command effects
  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    wp_d      = wp_q;
    shown_d   = shown_q;
    elapsed_d = elapsed_q;
    rd_idx_d  = rd_idx_q;
    base_d    = base_q;
    mem_we    = 1'b0;
    mem_waddr = wp_q;
    mem_wdata = 8'd0;
    mem_re    = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == ADDR_W'(STORE_BYTES - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + ADDR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          case (cmd_e'(in_i.data.cmd))
            CMD_TICK: begin
              if (elapsed_q != ELAPSED_MAX) begin
                elapsed_d = elapsed_q + 17'd1;
              end
            end
            CMD_SELECT: begin
              if (in_i.data.slot_index < {4'd0, n_eff}) begin
                wp_d = sel_pos;
              end
            end
            CMD_WRITE: begin
              if (wp_q < store_end && wp_q < ADDR_W'(STORE_BYTES)) begin
                mem_we    = 1'b1;
                mem_waddr = wp_q;
                mem_wdata = in_i.data.char_code;
                wp_d      = wp_inc;
                if (wp_inc < store_end && wp_inc < ADDR_W'(STORE_BYTES)) begin
                  state_d = S_TERM;
                end
              end
            end
            CMD_CLEAR: begin
              wp_d      = '0;
              mem_we    = 1'b1;
              mem_waddr = '0;
            end
            CMD_RENDER: begin
              rd_idx_d = 5'd0;
              base_d   = base_now;
              state_d  = S_RENDER;
            end
            default: ;
          endcase
        end
      end
      S_TERM: begin
        // terminate the text after the character just stored
        mem_we    = 1'b1;
        mem_waddr = wp_q;
        state_d   = S_IDLE;
      end
      S_RENDER: begin
        if (issue) begin
          mem_re   = 1'b1;
          rd_idx_d = rd_idx_q + 5'd1;
          if (rd_last) begin
            state_d = S_IDLE;
            if ({1'b0, item_delay_q} < elapsed_q) begin
              shown_d   = (shown_inc >= n_eff) ? 3'd0 : shown_inc[2:0];
              elapsed_d = 17'd0;
            end
          end
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      wp_q      <= '0;
      shown_q   <= 3'd0;
      elapsed_q <= 17'd0;
      rd_idx_q  <= 5'd0;
      base_q    <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      wp_q      <= wp_d;
      shown_q   <= shown_d;
      elapsed_q <= elapsed_d;
      rd_idx_q  <= rd_idx_d;
      base_q    <= base_d;
    end
  end

  // Store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Hold the read word until taken; track its place in the run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else if (mem_re) begin
      rd_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      rd_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_first_q <= (rd_idx_q == 5'd0);
      rd_last_q  <= rd_last;
    end
    if (rd_valid_q && out_o.ready) begin
      ended_q <= ended_now;
    end
  end

  // Pad with spaces from the terminator onwards
  assign ended_now = (!rd_first_q && ended_q) || (rdata_q == 8'd0);

  assign out_o.valid            = rd_valid_q;
  assign out_o.data.out_char    = ended_now ? PAD_CHAR : rdata_q;
  assign out_o.data.last_of_run = rd_last_q;

endmodule

`default_nettype wire

### hdl/rtsd_checker.sv
// Port-level checker for the rotating text slot display, bound to the top level.
// Depends on rtsd_pkg and the assertion macros header.
`default_nettype none
`include "rotating_text_slot_display_assert.svh"

module rtsd_checker
  import rtsd_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [2:0] in_cmd,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       out_last
);

  // A stalled word holds
  `RTSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))

  // No new command while a run is still being read out
  `RTSD_ASSERT_IMP(a_busy_mid_run, out_valid && !out_last, !in_ready)

  // A render closes the input for at least the next cycle
  `RTSD_ASSERT_NXT(a_render_busy, in_valid && in_ready && in_cmd == CMD_RENDER, !in_ready)

  // A run does not break before its last word
  `RTSD_ASSERT_NXT(a_run_gapless, out_valid && out_ready && !out_last, out_valid)

endmodule

bind rotating_text_slot_display rtsd_checker u_rtsd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (in_i.valid),
  .in_ready  (in_i.ready),
  .in_cmd    (in_i.data.cmd),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_char  (out_o.data.out_char),
  .out_last  (out_o.data.last_of_run)
);

`default_nettype wire
